FILE: src/ngga_pkg.sv
`default_nettype none

package ngga_pkg;

    localparam int MAX_LINE_DEF    = 256;
    localparam int COORD_CHARS_DEF = 10;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_G       = 8'h47;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_N       = 8'd78;
    localparam logic [7:0] CH_E       = 8'd69;

    localparam logic [2:0] TAG_LEN    = 3'd6;
    localparam logic [2:0] TIME_CHARS = 3'd6;
    localparam logic [1:0] SAT_CHARS  = 2'd2;
    localparam logic [2:0] LAST_COMMA = 3'd7;
    localparam logic [2:0] COMMA_TIME = 3'd1;
    localparam logic [2:0] COMMA_LAT  = 3'd2;
    localparam logic [2:0] COMMA_NS   = 3'd3;
    localparam logic [2:0] COMMA_LON  = 3'd4;
    localparam logic [2:0] COMMA_EW   = 3'd5;
    localparam logic [2:0] COMMA_SATS = 3'd7;

    localparam int         CIF_W   = 4;
    localparam logic [3:0] CIF_MAX = 4'd15;

    localparam logic [7:0] SEC_MAX  = 8'd59;
    localparam logic [7:0] MIN_MAX  = 8'd59;
    localparam logic [7:0] HOUR_MAX = 8'd23;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    // values handed from the line scanner at newline
    typedef struct packed {
        logic        valid;
        logic        has_time;
        logic [7:0]  hh;
        logic [7:0]  mm;
        logic [7:0]  ss;
        logic        n_seen;
        logic        north;
        logic        e_seen;
        logic        east;
        logic        has_sats;
        logic [7:0]  sats;
        logic [31:0] lat;
        logic [31:0] lon;
    } commit_t;

    typedef struct packed {
        logic [7:0]  hh;
        logic [7:0]  mm;
        logic [7:0]  ss;
        logic [7:0]  sats;
        logic [1:0]  hemi;
        logic        valid;
        logic [31:0] lat;
        logic [31:0] lon;
    } view_t;

    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = CH_G;
            3'd2:    c = CH_P;
            3'd3:    c = CH_G;
            3'd4:    c = CH_G;
            3'd5:    c = CH_A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // (a - '0') * 10 + (b - '0'), modulo 256
    function automatic logic [7:0] pair_of(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] da;
        logic [7:0] db;
        da = a - ASCII_ZERO;
        db = b - ASCII_ZERO;
        return 8'((da << 3) + (da << 1) + db);
    endfunction

endpackage

`default_nettype wire

FILE: src/ngga_scan.sv
`default_nettype none

module ngga_scan
    import ngga_pkg::*;
#(
    parameter int MAX_LINE    = MAX_LINE_DEF,
    parameter int COORD_CHARS = COORD_CHARS_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_en,
    input  wire logic [7:0] rx_byte,
    output commit_t         commit
);

    localparam int LEN_W = $clog2(MAX_LINE + 1);

    logic [LEN_W-1:0] len_reg,   len_next;
    logic [2:0]       prog_reg,  prog_next;
    logic [2:0]       comma_reg, comma_next;
    logic [3:0]       cif_reg,   cif_next;
    logic [2:0]       tpos_reg,  tpos_next;
    logic [1:0]       spos_reg,  spos_next;
    logic             f_time_reg,  f_time_next;
    logic             f_nseen_reg, f_nseen_next;
    logic             f_north_reg, f_north_next;
    logic             f_eseen_reg, f_eseen_next;
    logic             f_east_reg,  f_east_next;
    logic             f_sats_reg,  f_sats_next;

    logic [7:0] time_reg [6];
    logic [7:0] sat_reg  [2];
    logic [7:0] lat_reg  [COORD_CHARS];
    logic [7:0] lon_reg  [COORD_CHARS];

    logic is_nl;
    logic is_comma;
    logic matched;
    logic line_clr;
    logic wr_time;
    logic wr_sat;
    logic wr_lat;
    logic wr_lon;

    assign is_nl    = (rx_byte == CH_NL);
    assign is_comma = (rx_byte == CH_COMMA);
    assign matched  = (prog_reg == TAG_LEN);
    assign line_clr = byte_en && is_nl;

    always_comb
    begin
        len_next     = len_reg;
        prog_next    = prog_reg;
        comma_next   = comma_reg;
        cif_next     = cif_reg;
        tpos_next    = tpos_reg;
        spos_next    = spos_reg;
        f_time_next  = f_time_reg;
        f_nseen_next = f_nseen_reg;
        f_north_next = f_north_reg;
        f_eseen_next = f_eseen_reg;
        f_east_next  = f_east_reg;
        f_sats_next  = f_sats_reg;
        wr_time      = 1'b0;
        wr_sat       = 1'b0;
        wr_lat       = 1'b0;
        wr_lon       = 1'b0;

        if (byte_en && !is_nl && (len_reg < LEN_W'(MAX_LINE)))
        begin
            len_next = len_reg + 1'b1;
            if (matched)
            begin
                // time and satellite text is taken raw, commas included
                if (tpos_reg < TIME_CHARS)
                begin
                    wr_time   = 1'b1;
                    tpos_next = tpos_reg + 1'b1;
                end
                if (spos_reg < SAT_CHARS)
                begin
                    wr_sat    = 1'b1;
                    spos_next = spos_reg + 1'b1;
                end
                if (cif_reg == '0 && comma_reg == COMMA_NS && rx_byte == CH_N)
                    f_north_next = 1'b1;
                if (cif_reg == '0 && comma_reg == COMMA_EW && rx_byte == CH_E)
                    f_east_next = 1'b1;

                if (is_comma)
                begin
                    if (comma_reg < LAST_COMMA)
                    begin
                        comma_next = comma_reg + 1'b1;
                        case (comma_next)
                            COMMA_TIME:
                            begin
                                f_time_next = 1'b1;
                                tpos_next   = '0;
                            end
                            COMMA_NS:   f_nseen_next = 1'b1;
                            COMMA_EW:   f_eseen_next = 1'b1;
                            COMMA_SATS:
                            begin
                                f_sats_next = 1'b1;
                                spos_next   = '0;
                            end
                            default: ;
                        endcase
                    end
                    cif_next = '0;
                end
                else
                begin
                    if (cif_reg < CIF_W'(COORD_CHARS))
                    begin
                        wr_lat = (comma_reg == COMMA_LAT);
                        wr_lon = (comma_reg == COMMA_LON);
                    end
                    if (cif_reg < CIF_MAX)
                        cif_next = cif_reg + 1'b1;
                end
            end
            else if (rx_byte == tag_char(prog_reg))
                prog_next = prog_reg + 1'b1;
            else
                prog_next = (rx_byte == CH_DOLLAR) ? 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            prog_reg    <= '0;
            comma_reg   <= '0;
            cif_reg     <= '0;
            tpos_reg    <= TIME_CHARS;
            spos_reg    <= SAT_CHARS;
            f_time_reg  <= 1'b0;
            f_nseen_reg <= 1'b0;
            f_north_reg <= 1'b0;
            f_eseen_reg <= 1'b0;
            f_east_reg  <= 1'b0;
            f_sats_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
                time_reg[i] <= ASCII_ZERO;
            for (int i = 0; i < 2; i++)
                sat_reg[i] <= ASCII_ZERO;
            for (int i = 0; i < COORD_CHARS; i++)
            begin
                lat_reg[i] <= ASCII_ZERO;
                lon_reg[i] <= ASCII_ZERO;
            end
        end
        else if (line_clr)
        begin
            // newline: start a fresh line
            len_reg     <= '0;
            prog_reg    <= '0;
            comma_reg   <= '0;
            cif_reg     <= '0;
            tpos_reg    <= TIME_CHARS;
            spos_reg    <= SAT_CHARS;
            f_time_reg  <= 1'b0;
            f_nseen_reg <= 1'b0;
            f_north_reg <= 1'b0;
            f_eseen_reg <= 1'b0;
            f_east_reg  <= 1'b0;
            f_sats_reg  <= 1'b0;
            for (int i = 0; i < 6; i++)
                time_reg[i] <= ASCII_ZERO;
            for (int i = 0; i < 2; i++)
                sat_reg[i] <= ASCII_ZERO;
            for (int i = 0; i < COORD_CHARS; i++)
            begin
                lat_reg[i] <= ASCII_ZERO;
                lon_reg[i] <= ASCII_ZERO;
            end
        end
        else
        begin
            len_reg     <= len_next;
            prog_reg    <= prog_next;
            comma_reg   <= comma_next;
            cif_reg     <= cif_next;
            tpos_reg    <= tpos_next;
            spos_reg    <= spos_next;
            f_time_reg  <= f_time_next;
            f_nseen_reg <= f_nseen_next;
            f_north_reg <= f_north_next;
            f_eseen_reg <= f_eseen_next;
            f_east_reg  <= f_east_next;
            f_sats_reg  <= f_sats_next;
            for (int i = 0; i < 6; i++)
                if (wr_time && tpos_reg == 3'(i))
                    time_reg[i] <= rx_byte;
            for (int i = 0; i < 2; i++)
                if (wr_sat && spos_reg == 2'(i))
                    sat_reg[i] <= rx_byte;
            for (int i = 0; i < COORD_CHARS; i++)
            begin
                if (wr_lat && cif_reg == CIF_W'(i))
                    lat_reg[i] <= rx_byte;
                if (wr_lon && cif_reg == CIF_W'(i))
                    lon_reg[i] <= rx_byte;
            end
        end
    end

    always_comb
    begin
        commit.valid    = line_clr && matched;
        commit.has_time = f_time_reg;
        commit.hh       = pair_of(time_reg[0], time_reg[1]);
        commit.mm       = pair_of(time_reg[2], time_reg[3]);
        commit.ss       = pair_of(time_reg[4], time_reg[5]);
        commit.n_seen   = f_nseen_reg;
        commit.north    = f_north_reg;
        commit.e_seen   = f_eseen_reg;
        commit.east     = f_east_reg;
        commit.has_sats = f_sats_reg;
        commit.sats     = pair_of(sat_reg[0], sat_reg[1]);
        commit.lat      = {pair_of(lat_reg[0], lat_reg[1]), pair_of(lat_reg[2], lat_reg[3]),
                           pair_of(lat_reg[5], lat_reg[6]), pair_of(lat_reg[7], lat_reg[8])};
        commit.lon      = {pair_of(lon_reg[1], lon_reg[2]), pair_of(lon_reg[3], lon_reg[4]),
                           pair_of(lon_reg[6], lon_reg[7]), pair_of(lon_reg[8], lon_reg[9])};
    end

endmodule

`default_nettype wire

FILE: src/ngga_fix.sv
`default_nettype none

module ngga_fix
    import ngga_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire commit_t commit,
    input  wire logic    tick_en,
    input  wire logic    gps_enabled,
    output view_t        view
);

    logic [7:0]  hh_reg, mm_reg, ss_reg;
    logic [7:0]  sats_reg;
    logic [1:0]  hemi_reg;
    logic        valid_reg;
    logic [31:0] lat_reg, lon_reg;

    logic [7:0] ss_adv, mm_adv, hh_adv;
    logic [7:0] hh_next, mm_next, ss_next;
    logic [7:0] s_inc;
    logic       advance;

    assign advance = tick_en && !gps_enabled;
    assign s_inc   = ss_reg + 1'b1;

    always_comb
    begin
        ss_adv = s_inc;
        mm_adv = mm_reg;
        hh_adv = hh_reg;
        if (ss_adv > SEC_MAX)
        begin
            ss_adv = '0;
            mm_adv = mm_reg + 1'b1;
        end
        // a parsed value already past its limit rolls the same way
        if (mm_adv > MIN_MAX)
        begin
            mm_adv = '0;
            hh_adv = hh_reg + 1'b1;
        end
        if (hh_adv > HOUR_MAX)
            hh_adv = '0;

        hh_next = advance ? hh_adv : hh_reg;
        mm_next = advance ? mm_adv : mm_reg;
        ss_next = advance ? ss_adv : ss_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hh_reg    <= '0;
            mm_reg    <= '0;
            ss_reg    <= '0;
            sats_reg  <= '0;
            hemi_reg  <= '0;
            valid_reg <= 1'b0;
            lat_reg   <= '0;
            lon_reg   <= '0;
        end
        else if (commit.valid)
        begin
            if (commit.has_time)
            begin
                hh_reg <= commit.hh;
                mm_reg <= commit.mm;
                ss_reg <= commit.ss;
            end
            if (commit.n_seen)
                hemi_reg[0] <= commit.north;
            if (commit.e_seen)
                hemi_reg[1] <= commit.east;
            if (commit.has_sats)
                sats_reg <= commit.sats;
            valid_reg <= 1'b1;
            lat_reg   <= commit.lat;
            lon_reg   <= commit.lon;
        end
        else
        begin
            hh_reg <= hh_next;
            mm_reg <= mm_next;
            ss_reg <= ss_next;
        end
    end

    always_comb
    begin
        view.hh    = hh_next;
        view.mm    = mm_next;
        view.ss    = ss_next;
        view.sats  = sats_reg;
        view.hemi  = hemi_reg;
        view.valid = valid_reg;
        view.lat   = lat_reg;
        view.lon   = lon_reg;
    end

endmodule

`default_nettype wire

FILE: src/nmea_gga_parser_with_clock.sv
// GGA sentence parser with a local HH:MM:SS clock. Each word is a received
// character (opcode 0) or a one-second tick (opcode 1); only ticks produce a
// result, which carries the current time, the satellite count, the hemisphere
// flags and the latitude/longitude digit pairs from the last committed
// "$GPGGA" line (a newline commits it). A tick with gps_enabled low advances
// the local clock before it is reported. The block takes one word per clock
// while input ready is high: a word is held in an input register, goes through
// the line scanner and the fix/clock update, and a tick's result lands in the
// output register, which raises out_valid. Input ready drops only while a tick
// sits in the input register behind a result that has not been taken.
`default_nettype none

module nmea_gga_parser_with_clock
    import ngga_pkg::*;
#(
    parameter int MAX_LINE    = MAX_LINE_DEF,
    parameter int COORD_CHARS = COORD_CHARS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        gps_enabled,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       hour,
    output logic [7:0]       minute,
    output logic [7:0]       second,
    output logic [7:0]       sat_count,
    output logic             sats_shown,
    output logic [1:0]       hemisphere,
    output logic             coords_valid,
    output logic [31:0]      lat_pairs,
    output logic [31:0]      lon_pairs
);

    logic       in_valid_reg;
    opcode_t    op_reg;
    logic [7:0] byte_reg;
    logic       en_reg;

    logic       out_valid_reg, out_valid_next;
    view_t      res_reg;
    logic       res_en_reg;

    logic       go;
    logic       byte_go;
    logic       tick_go;
    commit_t    commit;
    view_t      view;

    // a character never produces a result, so only a tick waits on the output
    assign go       = in_valid_reg && (op_reg == OP_BYTE || !out_valid_reg || out_ready);
    assign byte_go  = go && (op_reg == OP_BYTE);
    assign tick_go  = go && (op_reg == OP_TICK);
    assign in_ready = !in_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg   <= opcode_t'(opcode);
            byte_reg <= rx_byte;
            en_reg   <= gps_enabled;
        end
    end

    ngga_scan #(
        .MAX_LINE    (MAX_LINE),
        .COORD_CHARS (COORD_CHARS)
    ) u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (byte_go),
        .rx_byte (byte_reg),
        .commit  (commit)
    );

    ngga_fix u_fix (
        .clk         (clk),
        .rst_n       (rst_n),
        .commit      (commit),
        .tick_en     (tick_go),
        .gps_enabled (en_reg),
        .view        (view)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tick_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (tick_go)
        begin
            res_reg    <= view;
            res_en_reg <= en_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hour         = res_reg.hh;
    assign minute       = res_reg.mm;
    assign second       = res_reg.ss;
    assign sat_count    = res_reg.sats;
    assign sats_shown   = res_en_reg;
    assign hemisphere   = res_reg.hemi;
    assign coords_valid = res_reg.valid;
    assign lat_pairs    = res_reg.lat;
    assign lon_pairs    = res_reg.lon;

`ifndef SYNTHESIS
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(tick_go))
        else $error("result appeared without a processed tick");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (in_valid_reg && op_reg == OP_TICK && out_valid_reg && !out_ready))
        else $error("input stalled without a blocked tick");

    a_byte_keeps_result: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_go && !out_ready) |=> (out_valid_reg == $past(out_valid_reg)))
        else $error("character word changed result valid");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_nmea_gga_parser_with_clock.sv
`timescale 1ns / 1ps

module tb_nmea_gga_parser_with_clock;
    import ngga_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam logic [47:0] GGA_TAG = {CH_DOLLAR, CH_G, CH_P, CH_G, CH_G, CH_A};

    typedef struct packed {
        opcode_t    op;
        logic [7:0] ch;
        logic       gps;
    } gga_word_t;

    typedef struct packed {
        logic [7:0]  hh;
        logic [7:0]  mm;
        logic [7:0]  ss;
        logic [7:0]  sats;
        logic        shown;
        logic [1:0]  hemi;
        logic        ok;
        logic [31:0] lat;
        logic [31:0] lon;
    } tick_report_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = 1'b0;
    logic [7:0]  rx_byte = 8'h00;
    logic        gps_enabled = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
    logic [7:0]  sat_count;
    logic        sats_shown;
    logic [1:0]  hemisphere;
    logic        coords_valid;
    logic [31:0] lat_pairs;
    logic [31:0] lon_pairs;

    gga_word_t    pending_words [$];
    tick_report_t tick_reports_q [$];
    gga_word_t    next_word;
    tick_report_t due;

    int send_idle_pct;
    int recv_idle_pct;
    bit sprinkle_ticks;
    int queued_items;
    int err_cnt;
    int cycle_cnt;
    int words_taken;
    int ticks_taken;
    int reports_checked;
    int lines_committed;

    // line scanner state
    int          ln_len;
    int          tag_hits;
    int          comma_no;
    int          fpos;
    int          time_at;
    int          sats_at;
    logic [7:0]  time_txt [6];
    logic [7:0]  lat_txt [COORD_CHARS_DEF];
    logic [7:0]  lon_txt [COORD_CHARS_DEF];
    logic [7:0]  sat_txt [2];
    logic        saw_time;
    logic        saw_ns;
    logic        is_north;
    logic        saw_ew;
    logic        is_east;
    logic        saw_sats;

    // committed fix and local clock
    logic [7:0]  clk_h;
    logic [7:0]  clk_m;
    logic [7:0]  clk_s;
    logic [7:0]  fix_sats;
    logic [1:0]  fix_hemi;
    logic        fix_ok;
    logic [31:0] fix_lat;
    logic [31:0] fix_lon;

    nmea_gga_parser_with_clock dut (.*);

    always #5 clk = ~clk;

    function automatic logic [7:0] digit_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = hi - ASCII_ZERO;
        ones = lo - ASCII_ZERO;
        return 8'(tens * 8'd10 + ones);
    endfunction

    task automatic clear_line();
        ln_len = 0;
        tag_hits = 0;
        comma_no = 0;
        fpos = 0;
        time_at = 6;
        sats_at = 2;
        {saw_time, saw_ns, is_north, saw_ew, is_east, saw_sats} = '0;
        foreach (time_txt[i]) time_txt[i] = ASCII_ZERO;
        foreach (lat_txt[i]) lat_txt[i] = ASCII_ZERO;
        foreach (lon_txt[i]) lon_txt[i] = ASCII_ZERO;
        foreach (sat_txt[i]) sat_txt[i] = ASCII_ZERO;
    endtask

    task automatic commit_line();
        if (saw_time)
        begin
            clk_h = digit_pair(time_txt[0], time_txt[1]);
            clk_m = digit_pair(time_txt[2], time_txt[3]);
            clk_s = digit_pair(time_txt[4], time_txt[5]);
        end
        if (saw_ns)
            fix_hemi[0] = is_north;
        if (saw_ew)
            fix_hemi[1] = is_east;
        if (saw_sats)
            fix_sats = digit_pair(sat_txt[0], sat_txt[1]);
        fix_ok = 1'b1;
        fix_lat = {digit_pair(lat_txt[0], lat_txt[1]), digit_pair(lat_txt[2], lat_txt[3]),
                   digit_pair(lat_txt[5], lat_txt[6]), digit_pair(lat_txt[7], lat_txt[8])};
        fix_lon = {digit_pair(lon_txt[1], lon_txt[2]), digit_pair(lon_txt[3], lon_txt[4]),
                   digit_pair(lon_txt[6], lon_txt[7]), digit_pair(lon_txt[8], lon_txt[9])};
        lines_committed++;
    endtask

    task automatic scan_field(input logic [7:0] b);
        // time and satellite captures are raw and run straight over commas
        if (time_at < 6)
        begin
            time_txt[time_at] = b;
            time_at++;
        end
        if (sats_at < 2)
        begin
            sat_txt[sats_at] = b;
            sats_at++;
        end
        if (fpos == 0 && comma_no == COMMA_NS && b == CH_N)
            is_north = 1'b1;
        if (fpos == 0 && comma_no == COMMA_EW && b == CH_E)
            is_east = 1'b1;
        if (b == CH_COMMA)
        begin
            if (comma_no < LAST_COMMA)
            begin
                comma_no++;
                if (comma_no == COMMA_TIME)
                begin
                    saw_time = 1'b1;
                    time_at = 0;
                end
                if (comma_no == COMMA_NS)
                    saw_ns = 1'b1;
                if (comma_no == COMMA_EW)
                    saw_ew = 1'b1;
                if (comma_no == COMMA_SATS)
                begin
                    saw_sats = 1'b1;
                    sats_at = 0;
                end
            end
            fpos = 0;
        end
        else
        begin
            if (fpos < COORD_CHARS_DEF)
            begin
                if (comma_no == COMMA_LAT)
                    lat_txt[fpos] = b;
                if (comma_no == COMMA_LON)
                    lon_txt[fpos] = b;
            end
            if (fpos < CIF_MAX)
                fpos++;
        end
    endtask

    task automatic scan_char(input logic [7:0] b);
        if (b == CH_NL)
        begin
            if (tag_hits == TAG_LEN)
                commit_line();
            clear_line();
        end
        else if (ln_len < MAX_LINE_DEF)
        begin
            ln_len++;
            if (tag_hits == TAG_LEN)
                scan_field(b);
            else if (b == GGA_TAG[47 - 8 * tag_hits -: 8])
                tag_hits++;
            else
                tag_hits = (b == CH_DOLLAR) ? 1 : 0;
        end
    endtask

    task automatic tick_clock(input logic gps);
        tick_report_t r;
        if (!gps)
        begin
            clk_s = clk_s + 8'd1;
            if (clk_s > SEC_MAX)
            begin
                clk_s = 8'd0;
                clk_m = clk_m + 8'd1;
            end
            if (clk_m > MIN_MAX)
            begin
                clk_m = 8'd0;
                clk_h = clk_h + 8'd1;
            end
            if (clk_h > HOUR_MAX)
                clk_h = 8'd0;
        end
        r.hh = clk_h;
        r.mm = clk_m;
        r.ss = clk_s;
        r.sats = fix_sats;
        r.shown = gps;
        r.hemi = fix_hemi;
        r.ok = fix_ok;
        r.lat = fix_lat;
        r.lon = fix_lon;
        tick_reports_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            err_cnt++;
        end
    endtask

    task automatic queue_tick(input logic gps);
        gga_word_t w;
        w.op = OP_TICK;
        w.ch = 8'($urandom_range(255));
        w.gps = gps;
        pending_words.push_back(w);
        queued_items++;
    endtask

    task automatic queue_char(input logic [7:0] b);
        gga_word_t w;
        if (sprinkle_ticks && $urandom_range(99) < 7)
            queue_tick(1'($urandom_range(1)));
        w.op = OP_BYTE;
        w.ch = b;
        w.gps = 1'($urandom_range(1));
        pending_words.push_back(w);
        queued_items++;
    endtask

    task automatic queue_text(input string s);
        for (int k = 0; k < s.len(); k++)
            queue_char(s[k]);
    endtask

    function automatic logic [7:0] rand_digit();
        if ($urandom_range(99) < 90)
            return 8'(ASCII_ZERO + $urandom_range(9));
        return 8'($urandom_range(255));
    endfunction

    task automatic queue_digits(input int len, input int dot_at);
        for (int k = 0; k < len; k++)
            queue_char(k == dot_at ? 8'h2E : rand_digit());
    endtask

    task automatic queue_hemi_field(input logic [7:0] good, input logic [7:0] other);
        case ($urandom_range(4))
            0, 1: queue_char(good);
            2:    queue_char(other);
            3:    queue_char(8'($urandom_range(255)));
            default: ;
        endcase
        if ($urandom_range(9) == 0)
            queue_digits($urandom_range(1, 3), -1);
    endtask

    task automatic queue_random_line();
        int nf;
        int len;
        if ($urandom_range(99) < 10)
        begin
            // noise line
            len = $urandom_range(1, 20);
            for (int k = 0; k < len; k++)
                queue_char(8'($urandom_range(255)));
            queue_char(CH_NL);
            return;
        end
        case ($urandom_range(9))
            0:       queue_text("$GPGSA");
            1:       queue_text("#$GP$GPGGA");
            default: queue_text("$GPGGA");
        endcase
        nf = ($urandom_range(99) < 70) ? $urandom_range(9, 12) : $urandom_range(0, 8);
        for (int f = 1; f <= nf; f++)
        begin
            queue_char(CH_COMMA);
            case (f)
                1:
                begin
                    if ($urandom_range(99) < 20)
                    begin
                        queue_text("23595");
                        queue_digits(1, -1);
                    end
                    else
                        queue_digits(($urandom_range(99) < 85) ? 6 : $urandom_range(0, 9), -1);
                end
                2: queue_digits($urandom_range(0, 13), 4);
                3: queue_hemi_field(CH_N, 8'h53);
                4: queue_digits($urandom_range(0, 14), 5);
                5: queue_hemi_field(CH_E, 8'h57);
                6: queue_digits(1, -1);
                7: queue_digits(($urandom_range(99) < 80) ? 2 : $urandom_range(0, 3), -1);
                default:
                begin
                    if ($urandom_range(19) == 0)
                        queue_text("$GPGGA");
                    queue_digits($urandom_range(0, 4), -1);
                end
            endcase
        end
        if ($urandom_range(99) < 95)
            queue_char(CH_NL);
        if ($urandom_range(99) < 60)
            queue_tick(1'($urandom_range(1)));
    endtask

    // runs past the length cap; the tail, commas included, must be dropped
    task automatic queue_long_line();
        queue_text("$GPGGA,123456,");
        for (int k = 0; k < MAX_LINE_DEF + 8; k++)
            queue_char(($urandom_range(9) == 0) ? CH_COMMA : rand_digit());
        queue_char(CH_NL);
        queue_tick(1'b1);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || in_valid || tick_reports_q.size() != 0);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            opcode <= OP_BYTE;
            rx_byte <= 8'h00;
            gps_enabled <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                words_taken++;
                if (opcode == OP_TICK)
                begin
                    ticks_taken++;
                    tick_clock(gps_enabled);
                end
                else
                    scan_char(rx_byte);
            end
            // hold the word until it is taken
            if (!in_valid || in_ready)
            begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_word.op;
                    rx_byte <= next_word.ch;
                    gps_enabled <= next_word.gps;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (tick_reports_q.size() == 0)
                begin
                    $display("%0t: unexpected report, expected none, got %0d:%0d:%0d", $time,
                             hour, minute, second);
                    err_cnt++;
                end
                else
                begin
                    due = tick_reports_q.pop_front();
                    check_field("hour", due.hh, hour);
                    check_field("minute", due.mm, minute);
                    check_field("second", due.ss, second);
                    check_field("sat_count", due.sats, sat_count);
                    check_field("sats_shown", due.shown, sats_shown);
                    check_field("hemisphere", due.hemi, hemisphere);
                    check_field("coords_valid", due.ok, coords_valid);
                    check_field("lat_pairs", due.lat, lat_pairs);
                    check_field("lon_pairs", due.lon, lon_pairs);
                    reports_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d reports still due", cycle_cnt,
                     tick_reports_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clear_line();
        {clk_h, clk_m, clk_s, fix_sats} = '0;
        fix_hemi = 2'b00;
        fix_ok = 1'b0;
        fix_lat = '0;
        fix_lon = '0;
        send_idle_pct = 30;
        recv_idle_pct = 52;
        sprinkle_ticks = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset view, a local tick, extreme bytes, then a line that rolls over
        queue_tick(1'b1);
        queue_tick(1'b0);
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_text("$GPGGA,235959");
        queue_char(CH_NL);
        queue_tick(1'b0);
        queue_tick(1'b1);
        wait_drained();

        sprinkle_ticks = 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            queued_items = 0;
            case (phase)
                0:
                begin
                    send_idle_pct = 30;
                    recv_idle_pct = 52;
                end
                1:
                begin
                    send_idle_pct = 52;
                    recv_idle_pct = 30;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    queue_long_line();
                end
            endcase
            while (queued_items < 45)
                queue_random_line();
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (tick_reports_q.size() != 0)
        begin
            $display("%0t: %0d reports expected, got 0", $time, tick_reports_q.size());
            err_cnt++;
        end
        $display("run covered %0d words (%0d ticks), %0d GGA lines committed",
                 words_taken, ticks_taken, lines_committed);
        $display("%0d tick reports compared over three pacing phases, %0d mismatches",
                 reports_checked, err_cnt);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
